// File: sv/wbc_pkg.sv
// Package: word break checker sizes, transaction types and shared codes
`timescale 1ns / 1ps

package wbc_pkg;

    localparam int NUM_WORDS    = 16;
    localparam int MAX_WORD_LEN = 16;
    localparam int CHAR_W       = 8;

    localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CIDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CNT_W  = $clog2(NUM_WORDS + 1);
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int LLEN_W = $clog2(MAX_WORD_LEN + 2);

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_WORD_CHAR = 2'd1,
        OP_TEXT_CHAR = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CHAR_W-1:0] char_code;
        logic              word_end;
        logic              text_start;
    } t_in_item;

    typedef struct packed {
        logic prefix_segmentable;
        logic dictionary_dropped;
    } t_out_item;

    typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] t_row;
    typedef logic [MAX_WORD_LEN:0]               t_okb;

    typedef struct packed {
        logic              char_we;
        logic              len_we;
        logic [WIDX_W-1:0] word;
        logic [CIDX_W-1:0] slot;
        logic [CHAR_W-1:0] char_code;
        logic [LEN_W-1:0]  length;
    } t_store_wr;

endpackage

// File: sv/word_break_checker.sv
// Top level: word break checker with dictionary store and word-by-word scan
//
//   channel | valid   | ready   | payload | transaction
//   input   | i_valid | o_ready | i_item  | clear, dictionary char or text char
//   output  | o_valid | i_ready | o_item  | one result per text char
//
// Clear and dictionary characters are taken while idle. A text character scans
// the stored words (none stored: no scan), one stored word per cycle through
// the store's single read port and the shared match unit, then a wait state finishes it.
// Reset (i_rst_n low, synchronous) empties the store and starts a new text.
// A result waits in the output register; a finished scan holds until it is free.
`timescale 1ns / 1ps

module word_break_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wbc_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output wbc_pkg::t_out_item o_item
);
    import wbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_word_count, n_word_count;
    logic [LLEN_W-1:0] r_load_len, n_load_len;
    t_row              r_text, n_text;
    t_okb              r_okb, n_okb;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic              r_dropped, n_dropped;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic              r_cmp_vld;
    logic              r_ok, n_ok;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    t_store_wr         store_wr;
    t_row              rd_row;
    logic [LEN_W-1:0]  rd_len;
    logic              hit;
    logic              accept;
    logic              out_free;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_item   = r_out;

    wbc_word_store u_store (
        .i_clk   (i_clk),
        .i_wr    (store_wr),
        .i_raddr (r_widx),
        .o_row   (rd_row),
        .o_len   (rd_len)
    );

    wbc_match_unit u_match (
        .i_row  (rd_row),
        .i_len  (rd_len),
        .i_text (r_text),
        .i_okb  (r_okb),
        .i_pos  (r_pos),
        .o_hit  (hit)
    );

    always_comb begin
        logic [LLEN_W-1:0] len_inc;
        t_row              base_text;
        t_okb              base_okb;
        logic [LEN_W-1:0]  base_pos;

        n_state      = r_state;
        n_word_count = r_word_count;
        n_load_len   = r_load_len;
        n_text       = r_text;
        n_okb        = r_okb;
        n_pos        = r_pos;
        n_dropped    = r_dropped;
        n_widx       = r_widx;
        n_ok         = r_ok;
        n_out_vld    = r_out_vld && !i_ready;
        n_out        = r_out;

        len_inc   = (r_load_len <= LLEN_W'(MAX_WORD_LEN)) ? r_load_len + 1'b1 : r_load_len;
        base_text = i_item.text_start ? '0 : r_text;
        base_okb  = i_item.text_start ? t_okb'(1) : r_okb;
        base_pos  = i_item.text_start ? '0 : r_pos;

        store_wr           = '0;
        store_wr.word      = r_word_count[WIDX_W-1:0];
        store_wr.slot      = r_load_len[CIDX_W-1:0];
        store_wr.char_code = i_item.char_code;
        store_wr.length    = len_inc[LEN_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_item.operation))
                        OP_CLEAR: begin
                            n_word_count = '0;
                            n_load_len   = '0;
                            n_dropped    = 1'b0;
                        end
                        OP_WORD_CHAR: begin
                            store_wr.char_we = (r_load_len < LLEN_W'(MAX_WORD_LEN)) &&
                                               (r_word_count < CNT_W'(NUM_WORDS));
                            n_load_len = len_inc;
                            if (i_item.word_end) begin
                                n_load_len = '0;
                                if ((len_inc > LLEN_W'(MAX_WORD_LEN)) ||
                                    (r_word_count >= CNT_W'(NUM_WORDS))) begin
                                    n_dropped = 1'b1;
                                end else begin
                                    store_wr.len_we = 1'b1;
                                    n_word_count    = r_word_count + 1'b1;
                                end
                            end
                        end
                        OP_TEXT_CHAR: begin
                            n_text = {base_text[MAX_WORD_LEN-2:0], i_item.char_code};
                            n_okb  = {base_okb[MAX_WORD_LEN-1:0], 1'b0};
                            n_pos  = (base_pos < LEN_W'(MAX_WORD_LEN)) ? base_pos + 1'b1
                                                                        : base_pos;
                            n_widx = '0;
                            n_ok   = 1'b0;
                            n_state = (r_word_count == '0) ? S_WAIT : S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_ok   = r_ok || (r_cmp_vld && hit);
                n_widx = r_widx + 1'b1;
                if (CNT_W'(r_widx) + 1'b1 == r_word_count) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_ok = r_ok || (r_cmp_vld && hit);
                if (out_free) begin
                    n_okb[0]  = n_ok;
                    n_out_vld = 1'b1;
                    n_out.prefix_segmentable = n_ok;
                    n_out.dictionary_dropped = r_dropped;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_word_count <= '0;
            r_load_len   <= '0;
            r_text       <= '0;
            r_okb        <= t_okb'(1);
            r_pos        <= '0;
            r_dropped    <= 1'b0;
            r_widx       <= '0;
            r_cmp_vld    <= 1'b0;
            r_ok         <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_word_count <= n_word_count;
            r_load_len   <= n_load_len;
            r_text       <= n_text;
            r_okb        <= n_okb;
            r_pos        <= n_pos;
            r_dropped    <= n_dropped;
            r_widx       <= n_widx;
            r_cmp_vld    <= (r_state == S_SCAN);
            r_ok         <= n_ok;
            r_out_vld    <= n_out_vld;
        end
        r_out <= n_out;
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_widx) < r_word_count))
        else $error("scan index beyond stored words");

    a_text_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.operation == OP_TEXT_CHAR)) |=> !o_ready)
        else $error("ready during text scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_word_count <= CNT_W'(NUM_WORDS)) && (r_load_len <= LLEN_W'(MAX_WORD_LEN + 1)))
        else $error("word count or load length out of range");

    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_WAIT))
        else $error("result without finished scan");

    a_okb_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> (r_okb[0] == r_out.prefix_segmentable))
        else $error("segmentable bit not recorded");

endmodule

// File: sv/wbc_word_store.sv
// Dictionary store: one row of characters and one length per word, registered read
`timescale 1ns / 1ps

module wbc_word_store (
    input  logic                      i_clk,
    input  wbc_pkg::t_store_wr        i_wr,
    input  logic [wbc_pkg::WIDX_W-1:0] i_raddr,
    output wbc_pkg::t_row             o_row,
    output logic [wbc_pkg::LEN_W-1:0] o_len
);
    import wbc_pkg::*;

    t_row             r_chars [NUM_WORDS];
    logic [LEN_W-1:0] r_lens  [NUM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr.char_we) begin
            r_chars[i_wr.word][i_wr.slot] <= i_wr.char_code;
        end
        o_row <= r_chars[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.len_we) begin
            r_lens[i_wr.word] <= i_wr.length;
        end
        o_len <= r_lens[i_raddr];
    end

endmodule

// File: sv/wbc_match_unit.sv
// Match unit: checks one stored word against the text ending at the newest character
`timescale 1ns / 1ps

module wbc_match_unit (
    input  wbc_pkg::t_row             i_row,
    input  logic [wbc_pkg::LEN_W-1:0] i_len,
    input  wbc_pkg::t_row             i_text,
    input  wbc_pkg::t_okb             i_okb,
    input  logic [wbc_pkg::LEN_W-1:0] i_pos,
    output logic                      o_hit
);
    import wbc_pkg::*;

    logic [MAX_WORD_LEN-1:0] lane_ok;

    always_comb begin
        logic [LEN_W-1:0]  back;
        logic [CIDX_W-1:0] tidx;
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
            back       = LEN_W'(int'(i_len) - 1 - j);
            tidx       = back[CIDX_W-1:0];
            lane_ok[j] = (LEN_W'(j) >= i_len) || (i_row[j] == i_text[tidx]);
        end
    end

    assign o_hit = (i_len != '0) && (i_len <= i_pos) && i_okb[i_len] && (&lane_ok);

endmodule

// File: verif/tb_word_break_checker.sv
// Testbench: word break checker driven with dictionary loads and texts, checked per text character
`timescale 1ns / 1ps

module tb_word_break_checker;
    import wbc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_GOAL      = 1400;
    localparam int VOCAB_MAX      = 64;
    localparam int VOCAB_WLEN     = 20;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int STALL_LIMIT    = 3000;

    class word_break_tracker;
        logic [CHAR_W-1:0]     word_chars [NUM_WORDS][MAX_WORD_LEN];
        int                    word_len [NUM_WORDS];
        int                    word_count;
        int                    load_len;
        logic [CHAR_W-1:0]     recent_text [MAX_WORD_LEN];
        logic [MAX_WORD_LEN:0] ok_bits;
        int                    text_pos;
        bit                    dropped;
        t_out_item             pending_verdicts [$];
        int                    mismatches;

        function new();
            word_count = 0;
            load_len   = 0;
            dropped    = 1'b0;
            mismatches = 0;
            restart_text();
        endfunction

        function void restart_text();
            foreach (recent_text[k]) recent_text[k] = '0;
            ok_bits    = '0;
            ok_bits[0] = 1'b1;
            text_pos   = 0;
        endfunction

        function void note_item(t_in_item it);
            int        len;
            bit        hit;
            bit        same;
            t_out_item verdict;
            case (it.operation)
                OP_CLEAR: begin
                    word_count = 0;
                    load_len   = 0;
                    dropped    = 1'b0;
                end
                OP_WORD_CHAR: begin
                    if (load_len < MAX_WORD_LEN && word_count < NUM_WORDS)
                        word_chars[word_count][load_len] = it.char_code;
                    if (load_len <= MAX_WORD_LEN)
                        load_len++;
                    if (it.word_end) begin
                        len      = load_len;
                        load_len = 0;
                        if (len > MAX_WORD_LEN || word_count >= NUM_WORDS) begin
                            dropped = 1'b1;
                        end else begin
                            word_len[word_count] = len;
                            word_count++;
                        end
                    end
                end
                OP_TEXT_CHAR: begin
                    if (it.text_start)
                        restart_text();
                    for (int k = MAX_WORD_LEN - 1; k > 0; k--)
                        recent_text[k] = recent_text[k-1];
                    recent_text[0] = it.char_code;
                    ok_bits = {ok_bits[MAX_WORD_LEN-1:0], 1'b0};
                    if (text_pos < MAX_WORD_LEN)
                        text_pos++;
                    hit = 1'b0;
                    for (int w = 0; w < word_count; w++) begin
                        len = word_len[w];
                        if (len == 0 || len > text_pos || !ok_bits[len])
                            continue;
                        same = 1'b1;
                        for (int k = 0; k < len; k++)
                            if (recent_text[k] != word_chars[w][len-1-k])
                                same = 1'b0;
                        if (same)
                            hit = 1'b1;
                    end
                    ok_bits[0] = hit;
                    verdict.prefix_segmentable = hit;
                    verdict.dictionary_dropped = dropped;
                    pending_verdicts.push_back(verdict);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result seg=%b drop=%b",
                             got.prefix_segmentable, got.dictionary_dropped);
                return;
            end
            exp = pending_verdicts.pop_front();
            if (got.prefix_segmentable !== exp.prefix_segmentable ||
                got.dictionary_dropped !== exp.dictionary_dropped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch seg exp=%b got=%b, drop exp=%b got=%b",
                             exp.prefix_segmentable, got.prefix_segmentable,
                             exp.dictionary_dropped, got.dictionary_dropped);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    word_break_tracker board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_asked = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;
    int stall_cycles  = 0;
    int items_sent    = 0;

    logic [CHAR_W-1:0] alphabet [4];
    int                alpha_n;
    logic [CHAR_W-1:0] vocab_chars [VOCAB_MAX][VOCAB_WLEN];
    int                vocab_len [VOCAB_MAX];
    int                vocab_n = 0;

    word_break_checker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            i_ready      <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_asked != holdoff_seen) begin
            i_ready      <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_seen <= holdoff_asked;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready === 1'b1)
            board.note_item(i_item);
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            board.check_result(o_item);
        if (i_rst_n && ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic wend, input logic tstart);
        t_in_item it;
        it.operation  = op;
        it.char_code  = ch;
        it.word_end   = wend;
        it.text_start = tstart;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_word(input int len);
        int                slot;
        logic [CHAR_W-1:0] ch;
        slot = vocab_n;
        vocab_n++;
        vocab_len[slot] = len;
        for (int k = 0; k < len; k++) begin
            ch = alphabet[$urandom_range(0, alpha_n - 1)];
            vocab_chars[slot][k] = ch;
            send_item(OP_WORD_CHAR, ch, k == len - 1, 1'($urandom_range(0, 1)));
        end
    endtask

    // texts are mostly concatenations of loaded words, with stray chars mixed in
    task automatic send_text(input int nwords, input bit marked);
        int w;
        bit first;
        first = marked;
        for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(0, 49) == 0)
                send_item(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (vocab_n == 0 || $urandom_range(0, 9) == 0) begin
                send_item(OP_TEXT_CHAR, CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), first);
                first = 1'b0;
            end else begin
                w = $urandom_range(0, vocab_n - 1);
                for (int k = 0; k < vocab_len[w]; k++) begin
                    send_item(OP_TEXT_CHAR, vocab_chars[w][k], 1'($urandom_range(0, 1)),
                              first);
                    first = 1'b0;
                end
            end
        end
    endtask

    initial begin
        int phase;
        int nwords;
        int r;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        phase = 1;
        send_idle_pct = 15;
        recv_idle_pct <= 72;

        // text before any start mark, ignored opcode, clear abandoning a partial word
        send_item(OP_TEXT_CHAR, 8'h78, 1'b1, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
        send_item(OP_WORD_CHAR, 8'h55, 1'b0, 1'b0);
        send_item(OP_CLEAR, 8'hFF, 1'b1, 1'b1);
        send_item(OP_TEXT_CHAR, 8'h55, 1'b0, 1'b1);
        send_item(OP_WORD_CHAR, 8'h00, 1'b1, 1'b1);
        send_item(OP_WORD_CHAR, 8'hFF, 1'b0, 1'b1);
        send_item(OP_WORD_CHAR, 8'h00, 1'b1, 1'b0);
        send_item(OP_WORD_CHAR, 8'h00, 1'b1, 1'b0);
        send_item(OP_TEXT_CHAR, 8'h00, 1'b1, 1'b1);
        send_item(OP_TEXT_CHAR, 8'hFF, 1'b0, 1'b0);
        send_item(OP_TEXT_CHAR, 8'h00, 1'b1, 1'b0);
        send_item(OP_TEXT_CHAR, 8'h00, 1'b0, 1'b0);
        send_item(OP_TEXT_CHAR, 8'hFF, 1'b0, 1'b1);
        send_item(OP_TEXT_CHAR, 8'h00, 1'b0, 1'b0);
        send_item(OP_CLEAR, 8'h00, 1'b0, 1'b0);

        while (items_sent < ITEM_GOAL) begin
            if (phase == 1 && items_sent >= ITEM_GOAL / 3) begin
                phase = 2;
                send_idle_pct = 72;
                recv_idle_pct <= 15;
            end else if (phase == 2 && items_sent >= 2 * ITEM_GOAL / 3) begin
                phase = 3;
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                holdoff_asked <= holdoff_asked + 1;
            end
            if (vocab_n > 40 || $urandom_range(0, 3) == 0) begin
                send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                vocab_n = 0;
            end
            alpha_n = $urandom_range(1, 3);
            foreach (alphabet[i]) alphabet[i] = CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
                // overfill the store with short words
                for (int i = 0; i < 18; i++)
                    send_word($urandom_range(1, 2));
            end else begin
                nwords = $urandom_range(1, 4);
                for (int i = 0; i < nwords; i++) begin
                    r = $urandom_range(0, 15);
                    if (r < 11)
                        send_word($urandom_range(1, 4));
                    else if (r < 13)
                        send_word($urandom_range(5, 15));
                    else if (r == 13)
                        send_word(MAX_WORD_LEN);
                    else
                        send_word($urandom_range(MAX_WORD_LEN + 1, VOCAB_WLEN));
                end
            end
            r = $urandom_range(1, 3);
            for (int i = 0; i < r; i++)
                send_text($urandom_range(1, 8), $urandom_range(0, 7) != 0);
        end
        i_valid <= 1'b0;

        while (board.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: word_break_checker.f
sv/wbc_pkg.sv
sv/wbc_word_store.sv
sv/wbc_match_unit.sv
sv/word_break_checker.sv
verif/tb_word_break_checker.sv
